// File: rtl/rdse_pkg.sv
// ----------------------------------------------------------------------------
// rdse_pkg
// Shared constants, types and the digit-to-character table of the radix
// digit string encoder.
// ----------------------------------------------------------------------------
package rdse_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int PAD_W          = 5;
	localparam int CHAR_W         = 7;
	localparam int DIGIT_W        = 6;
	localparam int STORE_DEPTH    = 32;
	localparam int STORE_AW       = 5;
	localparam int CNT_W          = 6;
	localparam int CHUNK          = 8;
	localparam int JOB_DEPTH      = 2;
	localparam int OUT_DEPTH      = 4;
	localparam int OUT_CNT_W      = 3;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [PAD_W-1:0]   PAD_RESET   = 5'd0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

	// Register indexes on the configuration port.
	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_PAD   = 1'b1;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_SIGN,
		B_ZERO,
		B_DIGIT,
		B_BAD
	} back_state_t;

	typedef enum logic [1:0] {
		KIND_SIGN,
		KIND_ZERO,
		KIND_DIGIT,
		KIND_BAD
	} char_kind_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ascii;
		logic              last;
		logic              bad;
	} out_char_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 6'd10) begin
			c = CHAR_ZERO + {1'b0, d};
		end else if (d < 6'd36) begin
			c = CHAR_A + {1'b0, d} - 7'd10;
		end else begin
			c = CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

// File: rtl/rdse_fifo.sv
// ----------------------------------------------------------------------------
// rdse_fifo
// Small first-in first-out queue of fixed-width entries.
// ----------------------------------------------------------------------------
module rdse_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     pop,
	output logic [WIDTH-1:0]         rdata,
	output logic                     full,
	output logic                     empty,
	output logic [$clog2(DEPTH):0]   count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]        entry_q [DEPTH];
	logic [AW-1:0]           wr_ptr_q;
	logic [AW-1:0]           rd_ptr_q;
	logic [$clog2(DEPTH):0]  count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full    = (count_q == ($clog2(DEPTH)+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {{$clog2(DEPTH){1'b0}}, do_push}
				- {{$clog2(DEPTH){1'b0}}, do_pop};
		end
	end

endmodule

// File: rtl/rdse_front.sv
// ----------------------------------------------------------------------------
// rdse_front
// Classifies an incoming item: radix check, sign and magnitude, and packs
// the job for the conversion engine.
// ----------------------------------------------------------------------------
module rdse_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic [31:0]                   number,
	input  logic [rdse_pkg::RADIX_W-1:0]  radix,
	input  logic [rdse_pkg::PAD_W-1:0]    pad_zeros,
	output logic [VALUE_BITS+12:0]        job
);
	import rdse_pkg::*;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic                  bad;

	assign raw = number[VALUE_BITS-1:0];
	assign neg = raw[VALUE_BITS-1];
	// The most negative value negates to itself, which read unsigned is
	// exactly its magnitude.
	assign mag = neg ? (~raw + 1'b1) : raw;
	assign bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	assign job = {bad, neg, radix, pad_zeros, mag};

endmodule

// File: rtl/rdse_back.sv
// ----------------------------------------------------------------------------
// rdse_back
// Conversion engine: repeated division by the radix into the digit store,
// then character emission, sign and padding first, digits from the top.
// ----------------------------------------------------------------------------
module rdse_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  logic [VALUE_BITS+12:0]          job,
	output logic                            job_pop,
	input  logic [rdse_pkg::OUT_CNT_W-1:0]  out_count,
	output logic                            out_push,
	output rdse_pkg::out_char_t             out_data
);
	import rdse_pkg::*;

	localparam int DIV_W     = ((VALUE_BITS + CHUNK - 1) / CHUNK) * CHUNK;
	localparam int DIV_STEPS = DIV_W / CHUNK;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	back_state_t          state_q, state_d;
	logic [DIV_W-1:0]     work_q, work_d;
	logic [DIGIT_W-1:0]   rem_q, rem_d;
	logic [STEP_W-1:0]    step_q, step_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [RADIX_W-1:0]   radix_q, radix_d;
	logic                 neg_q, neg_d;
	logic [PAD_W-1:0]     zeros_q, zeros_d;
	logic [STORE_AW-1:0]  idx_q, idx_d;

	logic [DIGIT_W-1:0]   store [STORE_DEPTH];
	logic                 st_we;
	logic                 rd_en;

	logic                 issue;
	char_kind_t           issue_kind;
	logic                 issue_last;
	logic                 can_issue;

	logic                 valid_s1;
	char_kind_t           kind_s1;
	logic                 last_s1;
	logic [DIGIT_W-1:0]   digit_s1;

	logic [DIGIT_W-1:0]   chunk_rem;
	logic [CHUNK-1:0]     chunk_q;
	logic [DIGIT_W:0]     trial;
	logic [DIV_W-1:0]     work_next;

	// Eight restoring division steps on the remainder per cycle.
	always_comb begin
		chunk_rem = rem_q;
		chunk_q   = '0;
		trial     = '0;
		for (int k = 0; k < CHUNK; k++) begin
			trial = {chunk_rem, work_q[DIV_W-1-k]};
			if (trial >= {1'b0, radix_q}) begin
				trial = trial - {1'b0, radix_q};
				chunk_q[CHUNK-1-k] = 1'b1;
			end
			chunk_rem = trial[DIGIT_W-1:0];
		end
		work_next = (work_q << CHUNK) | DIV_W'(chunk_q);
	end

	// Room for the character in flight and the one about to be issued.
	assign can_issue = ({1'b0, out_count} + {{OUT_CNT_W{1'b0}}, valid_s1})
		< (OUT_CNT_W+1)'(OUT_DEPTH);

	always_comb begin
		state_d    = state_q;
		work_d     = work_q;
		rem_d      = rem_q;
		step_d     = step_q;
		cnt_d      = cnt_q;
		radix_d    = radix_q;
		neg_d      = neg_q;
		zeros_d    = zeros_q;
		idx_d      = idx_q;
		job_pop    = 1'b0;
		st_we      = 1'b0;
		rd_en      = 1'b0;
		issue      = 1'b0;
		issue_kind = KIND_DIGIT;
		issue_last = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					neg_d   = job[VALUE_BITS+11];
					radix_d = job[VALUE_BITS+10:VALUE_BITS+5];
					zeros_d = job[VALUE_BITS+4:VALUE_BITS];
					work_d  = DIV_W'(job[VALUE_BITS-1:0]);
					rem_d   = '0;
					step_d  = '0;
					cnt_d   = '0;
					state_d = job[VALUE_BITS+12] ? B_BAD : B_DIV;
				end
			end
			B_DIV: begin
				work_d = work_next;
				if (step_q == STEP_W'(DIV_STEPS-1)) begin
					// One digit done: store the remainder, keep the quotient.
					st_we  = 1'b1;
					cnt_d  = cnt_q + 1'b1;
					rem_d  = '0;
					step_d = '0;
					if ((work_next == '0) || (cnt_q == CNT_W'(STORE_DEPTH-1))) begin
						idx_d = cnt_q[STORE_AW-1:0];
						if (neg_q) begin
							state_d = B_SIGN;
						end else if (zeros_q != '0) begin
							state_d = B_ZERO;
						end else begin
							state_d = B_DIGIT;
						end
					end
				end else begin
					rem_d  = chunk_rem;
					step_d = step_q + 1'b1;
				end
			end
			B_SIGN: begin
				if (can_issue) begin
					issue      = 1'b1;
					issue_kind = KIND_SIGN;
					state_d    = (zeros_q != '0) ? B_ZERO : B_DIGIT;
				end
			end
			B_ZERO: begin
				if (can_issue) begin
					issue      = 1'b1;
					issue_kind = KIND_ZERO;
					zeros_d    = zeros_q - 1'b1;
					if (zeros_q == PAD_W'(1)) begin
						state_d = B_DIGIT;
					end
				end
			end
			B_DIGIT: begin
				if (can_issue) begin
					issue      = 1'b1;
					rd_en      = 1'b1;
					issue_kind = KIND_DIGIT;
					issue_last = (idx_q == '0);
					idx_d      = idx_q - 1'b1;
					if (idx_q == '0) begin
						state_d = B_IDLE;
					end
				end
			end
			B_BAD: begin
				if (can_issue) begin
					issue      = 1'b1;
					issue_kind = KIND_BAD;
					issue_last = 1'b1;
					state_d    = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[cnt_q[STORE_AW-1:0]] <= chunk_rem;
		end
		if (rd_en) begin
			digit_s1 <= store[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			work_q   <= '0;
			rem_q    <= '0;
			step_q   <= '0;
			cnt_q    <= '0;
			radix_q  <= RADIX_RESET;
			neg_q    <= 1'b0;
			zeros_q  <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			work_q   <= work_d;
			rem_q    <= rem_d;
			step_q   <= step_d;
			cnt_q    <= cnt_d;
			radix_q  <= radix_d;
			neg_q    <= neg_d;
			zeros_q  <= zeros_d;
			idx_q    <= idx_d;
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1 <= issue_kind;
			last_s1 <= issue_last;
		end
	end

	// The store read data is registered together with the issued character, so both arrive in the cycle after the issue.
	always_comb begin
		out_data.last = last_s1;
		out_data.bad  = 1'b0;
		unique case (kind_s1)
			KIND_SIGN:  out_data.ascii = CHAR_MINUS;
			KIND_ZERO:  out_data.ascii = CHAR_ZERO;
			KIND_DIGIT: out_data.ascii = digit_char(digit_s1);
			KIND_BAD: begin
				out_data.ascii = CHAR_NONE;
				out_data.bad   = 1'b1;
			end
			default:    out_data.ascii = CHAR_NONE;
		endcase
	end

	assign out_push = valid_s1;

endmodule

// File: rtl/radix_digit_string_encoder.sv
// ----------------------------------------------------------------------------
// radix_digit_string_encoder
// Converts signed integers into ASCII text in a configurable base.
// ----------------------------------------------------------------------------
// Usage: push one signed number per item while full is low. For each number
// the result side delivers its text one character per item, oldest first,
// while empty is low; pop takes a character. The string is an optional
// minus sign, pad_zeros extra zeros, then the digits, most significant first,
// with last_char set on the final one. A radix outside 2 to 36 gives a single
// item with bad_radix and last_char set and a zero character.
// A two-entry job queue decouples intake from conversion. Conversion runs
// one division by the radix per digit, eight restoring steps per cycle,
// then emits one character per cycle while the output queue has room.
// The division loop sets the rate. When the receiver stalls, the four-entry
// output queue fills and the engine waits; intake goes on until the job
// queue is full. Reset empties both queues, sets radix to 10 and pad_zeros
// to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module radix_digit_string_encoder #(
	parameter int VALUE_BITS = rdse_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rdse_pkg::APB_AW-1:0]    paddr,
	input  logic [rdse_pkg::APB_DW-1:0]    pwdata,
	output logic [rdse_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic signed [31:0]             number,
	output logic                           empty,
	input  logic                           pop,
	output logic [rdse_pkg::CHAR_W-1:0]    ascii_char,
	output logic                           last_char,
	output logic                           bad_radix
);
	import rdse_pkg::*;

	localparam int JOB_W = VALUE_BITS + 13;

	logic [RADIX_W-1:0]  radix_q;
	logic [PAD_W-1:0]    pad_zeros_q;
	logic                cfg_we;

	logic [JOB_W-1:0]    job_in;
	logic [JOB_W-1:0]    job_out;
	logic                job_full;
	logic                job_empty;
	logic                job_pop;
	logic [$clog2(JOB_DEPTH):0] job_count;

	out_char_t           out_wdata;
	out_char_t           out_rdata;
	logic                out_push;
	logic                out_full;
	logic [OUT_CNT_W-1:0] out_count;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			pad_zeros_q <= PAD_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == REG_RADIX) begin
				radix_q <= pwdata[RADIX_W-1:0];
			end else begin
				pad_zeros_q <= pwdata[PAD_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_PAD) ? {{(APB_DW-PAD_W){1'b0}}, pad_zeros_q}
		: {{(APB_DW-RADIX_W){1'b0}}, radix_q};

	rdse_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.number   (number),
		.radix    (radix_q),
		.pad_zeros(pad_zeros_q),
		.job      (job_in)
	);

	rdse_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_job_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_in),
		.pop   (job_pop),
		.rdata (job_out),
		.full  (job_full),
		.empty (job_empty),
		.count (job_count)
	);

	rdse_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!job_empty),
		.job      (job_out),
		.job_pop  (job_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	rdse_fifo #(
		.WIDTH($bits(out_char_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.pop   (pop),
		.rdata (out_rdata),
		.full  (out_full),
		.empty (empty),
		.count (out_count)
	);

	assign full       = job_full;
	assign ascii_char = out_rdata.ascii;
	assign last_char  = out_rdata.last;
	assign bad_radix  = out_rdata.bad;

	// The engine must never hand a character to a full output queue.
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("output queue overflow");

	// A job is only taken when one is waiting.
	a_job_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("job taken from an empty queue");

	// An error item always stands alone.
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bad_radix) |-> last_char)
		else $error("bad radix item without last_char");

	// The job queue never holds more than its depth.
	a_job_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_count <= ($clog2(JOB_DEPTH)+1)'(JOB_DEPTH))
		else $error("job queue count out of range");

endmodule
